// ----- rtl/assert_macros.svh -----
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a given clock, masked while reset is low.
`define ASSERT_CLK_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// Concurrent assertion on aclk, masked while aresetn is low.
`define ASSERT_ACLK(label, prop, msg) \
    `ASSERT_CLK_RST(label, aclk, aresetn, prop, msg)

`endif

// ----- rtl/brp_pkg.sv -----
`default_nettype none

package brp_pkg;

    // Fixed field widths
    localparam int BRP_POSITION_BITS = 24;
    localparam int BRP_CFG_BITS      = 24;
    localparam int BRP_HALF_BITS     = 16;
    localparam int BRP_ADDR_BITS     = 32;
    localparam int BRP_OFFSET_BITS   = 12;
    localparam int BRP_TYPE_BITS     = 4;
    localparam int BRP_STATUS_BITS   = 3;

    // Table layout
    localparam int BRP_HEADER_BYTES  = 8;
    localparam int BRP_ENTRY_BYTES   = 2;

    // Entry types
    localparam logic [BRP_TYPE_BITS-1:0] BRP_TYPE_PAD   = 4'd0;
    localparam logic [BRP_TYPE_BITS-1:0] BRP_TYPE_RELOC = 4'd3;

    // Request queue between parser and output stage
    localparam int BRP_QUEUE_DEPTH = 4;
    localparam int BRP_QPTR_BITS   = $clog2(BRP_QUEUE_DEPTH);
    localparam int BRP_QCNT_BITS   = $clog2(BRP_QUEUE_DEPTH + 1);

    typedef enum logic [BRP_STATUS_BITS-1:0] {
        BRP_ST_RELOC    = 3'd0,
        BRP_ST_END      = 3'd1,
        BRP_ST_BAD_SIZE = 3'd2,
        BRP_ST_BAD_TYPE = 3'd3,
        BRP_ST_PAST_END = 3'd4
    } brp_status_t;

    // One result request from the parser
    typedef struct packed {
        logic [BRP_ADDR_BITS-1:0]   page;
        logic [BRP_OFFSET_BITS-1:0] offset;
        brp_status_t                status;
        logic                       table_end;
    } brp_req_t;

endpackage

`default_nettype wire

// ----- rtl/brp_queue.sv -----
`default_nettype none

module brp_queue (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire brp_pkg::brp_req_t push_req,
    input  wire logic              pop,
    output brp_pkg::brp_req_t      head_req,
    output logic                   full,
    output logic                   empty
);
    import brp_pkg::*;

    brp_req_t                 slot_reg [BRP_QUEUE_DEPTH];
    logic [BRP_QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [BRP_QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [BRP_QCNT_BITS-1:0] count_reg, count_next;

    assign full     = (count_reg == BRP_QCNT_BITS'(BRP_QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign head_req = slot_reg[rd_ptr_reg];

    // Advance pointers with wrap at the queue depth
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == BRP_QPTR_BITS'(BRP_QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == BRP_QPTR_BITS'(BRP_QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the request
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_req;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/brp_front.sv -----
`default_nettype none

module brp_front #(
    parameter int POSITION_BITS = brp_pkg::BRP_POSITION_BITS
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic [brp_pkg::BRP_CFG_BITS-1:0] table_bytes,
    input  wire logic                             in_take,
    input  wire logic [brp_pkg::BRP_HALF_BITS-1:0] half_word,
    output logic                                  push,
    output brp_pkg::brp_req_t                     push_req
);
    import brp_pkg::*;

    localparam int PW1 = POSITION_BITS + 1;
    localparam int BW  = ((POSITION_BITS > BRP_ADDR_BITS) ? POSITION_BITS : BRP_ADDR_BITS) + 1;

    typedef enum logic [4:0] {
        PH_ADDR_LO = 5'b00001,
        PH_ADDR_HI = 5'b00010,
        PH_SIZE_LO = 5'b00100,
        PH_SIZE_HI = 5'b01000,
        PH_ENTRY   = 5'b10000
    } phase_t;

    phase_t                     phase_reg, phase_next;
    logic [POSITION_BITS-1:0]   pos_reg, pos_next;
    logic [POSITION_BITS-1:0]   left_reg, left_next;
    logic [BRP_ADDR_BITS-1:0]   page_reg, page_next;
    logic [BRP_HALF_BITS-1:0]   size_lo_reg, size_lo_next;
    logic                       fin_reg, fin_next;

    logic [POSITION_BITS-1:0]   tbl;
    logic [POSITION_BITS-1:0]   pos_inc;
    logic [BRP_ADDR_BITS-1:0]   size_val;
    logic [BRP_ADDR_BITS-1:0]   size_body;
    logic [BRP_TYPE_BITS-1:0]   entry_type;
    logic                       hdr_end;
    logic                       blk_end;
    logic                       size_bad;
    logic                       size_past;
    logic                       blk_done;
    logic                       reloc;
    logic                       err;

    // Table length at position width
    assign tbl     = POSITION_BITS'(table_bytes);
    assign pos_inc = pos_reg + POSITION_BITS'(BRP_ENTRY_BYTES);

    // At most a header's worth of bytes left, before and after this halfword
    assign hdr_end = ({1'b0, tbl} <= ({1'b0, pos_reg} + PW1'(BRP_HEADER_BYTES)));
    assign blk_end = ({1'b0, tbl} <= ({1'b0, pos_inc} + PW1'(BRP_HEADER_BYTES)));

    // Block size checks
    assign size_val   = {half_word, size_lo_reg};
    assign size_body  = size_val - BRP_ADDR_BITS'(BRP_HEADER_BYTES);
    assign size_bad   = (size_val < BRP_ADDR_BITS'(BRP_HEADER_BYTES)) || (size_val[1:0] != 2'b00);
    assign size_past  = ((BW'(pos_inc) + BW'(size_body)) > BW'(tbl));
    assign entry_type = half_word[BRP_HALF_BITS-1 -: BRP_TYPE_BITS];

    // Parse one halfword
    always_comb begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        left_next    = left_reg;
        page_next    = page_reg;
        size_lo_next = size_lo_reg;
        fin_next     = fin_reg;
        blk_done     = 1'b0;
        reloc        = 1'b0;
        err          = 1'b0;
        push         = 1'b0;
        push_req     = '{page: '0, offset: '0, status: BRP_ST_END, table_end: 1'b0};

        if (in_take && !fin_reg) begin
            if ((phase_reg == PH_ADDR_LO) && hdr_end) begin
                push     = 1'b1;
                push_req = '{page: '0, offset: '0, status: BRP_ST_END, table_end: 1'b1};
                fin_next = 1'b1;
            end else begin
                pos_next = pos_inc;
                unique case (phase_reg)
                    PH_ADDR_LO: begin
                        page_next  = {{(BRP_ADDR_BITS-BRP_HALF_BITS){1'b0}}, half_word};
                        phase_next = PH_ADDR_HI;
                    end
                    PH_ADDR_HI: begin
                        page_next  = {half_word, page_reg[BRP_HALF_BITS-1:0]};
                        phase_next = PH_SIZE_LO;
                    end
                    PH_SIZE_LO: begin
                        size_lo_next = half_word;
                        phase_next   = PH_SIZE_HI;
                    end
                    PH_SIZE_HI: begin
                        if (size_bad) begin
                            err      = 1'b1;
                            push_req = '{page: '0, offset: '0, status: BRP_ST_BAD_SIZE,
                                         table_end: 1'b1};
                        end else if (size_past) begin
                            err      = 1'b1;
                            push_req = '{page: '0, offset: '0, status: BRP_ST_PAST_END,
                                         table_end: 1'b1};
                        end else begin
                            left_next  = POSITION_BITS'(size_body);
                            phase_next = PH_ENTRY;
                            blk_done   = (size_body == '0);
                        end
                    end
                    PH_ENTRY: begin
                        if (entry_type == BRP_TYPE_RELOC) begin
                            reloc = 1'b1;
                        end else if (entry_type != BRP_TYPE_PAD) begin
                            err      = 1'b1;
                            push_req = '{page: '0, offset: '0, status: BRP_ST_BAD_TYPE,
                                         table_end: 1'b1};
                        end
                        if (!err) begin
                            left_next = (left_reg >= POSITION_BITS'(BRP_ENTRY_BYTES)) ?
                                        left_reg - POSITION_BITS'(BRP_ENTRY_BYTES) : '0;
                            blk_done  = (left_next == '0);
                        end
                    end
                    default: begin
                        phase_next = PH_ADDR_LO;
                    end
                endcase

                // Drop the parse on an error
                if (err) begin
                    push     = 1'b1;
                    fin_next = 1'b1;
                end else begin
                    if (blk_done) begin
                        phase_next = PH_ADDR_LO;
                    end
                    if (blk_done && blk_end) begin
                        push     = 1'b1;
                        fin_next = 1'b1;
                        push_req = reloc ?
                            '{page: page_reg, offset: half_word[BRP_OFFSET_BITS-1:0],
                              status: BRP_ST_RELOC, table_end: 1'b1} :
                            '{page: '0, offset: '0, status: BRP_ST_END, table_end: 1'b1};
                    end else if (reloc) begin
                        push     = 1'b1;
                        push_req = '{page: page_reg, offset: half_word[BRP_OFFSET_BITS-1:0],
                                     status: BRP_ST_RELOC, table_end: 1'b0};
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_ADDR_LO;
            pos_reg   <= '0;
            fin_reg   <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            fin_reg   <= fin_next;
        end
    end

    // Hold block data
    always_ff @(posedge aclk) begin
        left_reg    <= left_next;
        page_reg    <= page_next;
        size_lo_reg <= size_lo_next;
    end

endmodule

`default_nettype wire

// ----- rtl/brp_back.sv -----
`default_nettype none

module brp_back (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                q_empty,
    input  wire brp_pkg::brp_req_t                   q_head,
    output logic                                     q_pop,
    output logic [brp_pkg::BRP_ADDR_BITS-1:0]        reloc_address,
    output logic [brp_pkg::BRP_STATUS_BITS-1:0]      status,
    output logic                                     table_end,
    output logic                                     out_valid,
    input  wire logic                                out_ready
);
    import brp_pkg::*;

    logic                         valid_reg;
    logic [BRP_ADDR_BITS-1:0]     addr_reg;
    logic [BRP_STATUS_BITS-1:0]   status_reg;
    logic                         end_reg;

    // Advance when the output slot is free or being taken
    assign q_pop = !q_empty && (!valid_reg || out_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (q_pop) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    // Form the address: page plus offset, zero for non-relocation requests
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            addr_reg   <= q_head.page + BRP_ADDR_BITS'(q_head.offset);
            status_reg <= q_head.status;
            end_reg    <= q_head.table_end;
        end
    end

    assign out_valid     = valid_reg;
    assign reloc_address = addr_reg;
    assign status        = status_reg;
    assign table_end     = end_reg;

endmodule

`default_nettype wire

// ----- rtl/base_reloc_table_parser.sv -----
// Base relocation table parser.
// Input channel s_*: one little-endian halfword of the table per request,
// in table order. Result channel m_*: one result per relocation entry; the
// final result has m_table_end set and an end, error or relocation status.
// Config channel cfg_*: table length in bytes; always ready. The table length
// is to be written only while idle; the block itself does not enforce this.
// Throughput: one halfword per cycle while the queue has room. The parser
// decides each halfword in the cycle it is accepted and queues any result in
// a 4-entry request queue, written at the edge that accepts the halfword; the
// output register loads the queue head's page plus offset when free or taken.
// When m_ready is held low the queue fills and s_ready drops after 4 pending
// results plus the one in the output register; halfwords that give no result
// keep flowing while the queue has room.
// After the final result, halfwords are still accepted and dropped.
// Reset (aresetn low, synchronous) clears the parse position and state,
// the table length, the queue and the output valid flag.
`default_nettype none

module base_reloc_table_parser #(
    parameter int POSITION_BITS = brp_pkg::BRP_POSITION_BITS
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [brp_pkg::BRP_CFG_BITS-1:0]     cfg_table_bytes,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic [brp_pkg::BRP_HALF_BITS-1:0]    s_half_word,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic [brp_pkg::BRP_ADDR_BITS-1:0]         m_reloc_address,
    output logic [brp_pkg::BRP_STATUS_BITS-1:0]       m_status,
    output logic                                      m_table_end
);
    import brp_pkg::*;

    logic [BRP_CFG_BITS-1:0] table_bytes_reg;
    logic                    push;
    brp_req_t                push_req;
    brp_req_t                head_req;
    logic                    q_full;
    logic                    q_empty;
    logic                    q_pop;

    // Table length register
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            table_bytes_reg <= '0;
        end else if (cfg_valid) begin
            table_bytes_reg <= cfg_table_bytes;
        end
    end

    assign s_ready = !q_full;

    brp_front #(
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .table_bytes (table_bytes_reg),
        .in_take     (s_valid && s_ready),
        .half_word   (s_half_word),
        .push        (push),
        .push_req    (push_req)
    );

    brp_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_req (push_req),
        .pop      (q_pop),
        .head_req (head_req),
        .full     (q_full),
        .empty    (q_empty)
    );

    brp_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_empty       (q_empty),
        .q_head        (head_req),
        .q_pop         (q_pop),
        .reloc_address (m_reloc_address),
        .status        (m_status),
        .table_end     (m_table_end),
        .out_valid     (m_valid),
        .out_ready     (m_ready)
    );

endmodule

`default_nettype wire

// ----- rtl/brp_checker.sv -----
`default_nettype none
`include "assert_macros.svh"

module brp_checker (
    input wire logic                                 aclk,
    input wire logic                                 aresetn,
    input wire logic                                 m_valid,
    input wire logic                                 m_ready,
    input wire logic [brp_pkg::BRP_ADDR_BITS-1:0]    m_reloc_address,
    input wire logic [brp_pkg::BRP_STATUS_BITS-1:0]  m_status,
    input wire logic                                 m_table_end
);
    import brp_pkg::*;

    // Stalled result holds
    `ASSERT_ACLK(a_out_hold, (m_valid && !m_ready) |=> (m_valid && $stable(m_reloc_address) && $stable(m_status) && $stable(m_table_end)), "result changed while stalled")

    // Nothing follows the final result
    `ASSERT_ACLK(a_end_last, (m_valid && m_ready && m_table_end) |=> !m_valid, "result after table end")

    // Every non-relocation status finishes the parse
    `ASSERT_ACLK(a_status_ends, (m_valid && (m_status != BRP_ST_RELOC)) |-> m_table_end, "end or error status without table end")

    // Non-relocation results carry a zero address
    `ASSERT_ACLK(a_zero_addr, (m_valid && (m_status != BRP_ST_RELOC)) |-> (m_reloc_address == '0), "nonzero address on end or error")

endmodule

bind base_reloc_table_parser brp_checker u_brp_checker (.*);

`default_nettype wire

// ----- sim/base_reloc_table_parser_test.sv -----
`default_nettype none

import brp_pkg::*;

// Header halfwords in table order, then the entry stream of a block
typedef enum bit [2:0] {
    HDR_PAGE_LO,
    HDR_PAGE_HI,
    HDR_SIZE_LO,
    HDR_SIZE_HI,
    IN_ENTRIES
} hdr_phase_t;

typedef struct {
    bit [BRP_ADDR_BITS-1:0] addr;
    brp_status_t            status;
    bit                     table_end;
} reloc_result_t;

// Tracks the parse of the table and holds the results still due from the block
class reloc_parse_checker;
    bit [BRP_CFG_BITS-1:0]      table_len;
    bit [BRP_POSITION_BITS-1:0] pos;
    hdr_phase_t                 phase;
    bit [BRP_ADDR_BITS-1:0]     page;
    bit [BRP_HALF_BITS-1:0]     size_lo;
    bit [31:0]                  block_left;
    bit                         done;
    reloc_result_t              due[$];
    int                         mismatches;

    function bit [BRP_POSITION_BITS-1:0] table_bytes_left();
        return (table_len > pos) ? table_len - pos : '0;
    endfunction

    function void post(bit [BRP_ADDR_BITS-1:0] a, brp_status_t st, bit last);
        reloc_result_t r;
        r.addr      = a;
        r.status    = st;
        r.table_end = last;
        due.insert(due.size(), r);
        if (last)
            done = 1'b1;
    endfunction

    // Advance the parse by one accepted halfword request
    function void note_half(bit [BRP_HALF_BITS-1:0] hw);
        bit [31:0]              size;
        bit [BRP_ADDR_BITS-1:0] addr;
        bit                     reloc;
        bit [BRP_TYPE_BITS-1:0] kind;
        longint unsigned        reach;
        reloc = 1'b0;
        addr  = '0;
        if (done)
            return;
        // Table exhausted at a block start: the halfword is not used
        if (phase == HDR_PAGE_LO && table_bytes_left() <= BRP_HEADER_BYTES) begin
            post('0, BRP_ST_END, 1'b1);
            return;
        end
        pos = pos + BRP_POSITION_BITS'(BRP_ENTRY_BYTES);
        case (phase)
            HDR_PAGE_LO: begin
                page  = {16'h0000, hw};
                phase = HDR_PAGE_HI;
                return;
            end
            HDR_PAGE_HI: begin
                page[31:16] = hw;
                phase       = HDR_SIZE_LO;
                return;
            end
            HDR_SIZE_LO: begin
                size_lo = hw;
                phase   = HDR_SIZE_HI;
                return;
            end
            HDR_SIZE_HI: begin
                size = {hw, size_lo};
                if (size < BRP_HEADER_BYTES || size[1:0] != 2'b00) begin
                    post('0, BRP_ST_BAD_SIZE, 1'b1);
                    return;
                end
                reach = 64'(pos);
                reach = reach + 64'(size - 32'(BRP_HEADER_BYTES));
                if (reach > table_len) begin
                    post('0, BRP_ST_PAST_END, 1'b1);
                    return;
                end
                block_left = size - 32'(BRP_HEADER_BYTES);
                phase      = IN_ENTRIES;
            end
            default: begin
                kind = hw[15:12];
                if (kind == BRP_TYPE_RELOC) begin
                    reloc = 1'b1;
                    addr  = page + 32'(hw[11:0]);
                end else if (kind != BRP_TYPE_PAD) begin
                    post('0, BRP_ST_BAD_TYPE, 1'b1);
                    return;
                end
                block_left = (block_left >= 32'(BRP_ENTRY_BYTES)) ?
                             block_left - 32'(BRP_ENTRY_BYTES) : 32'd0;
            end
        endcase
        // Block complete: look for the end of the table
        if (block_left == 0) begin
            phase = HDR_PAGE_LO;
            if (table_bytes_left() <= BRP_HEADER_BYTES) begin
                if (reloc)
                    post(addr, BRP_ST_RELOC, 1'b1);
                else
                    post('0, BRP_ST_END, 1'b1);
                return;
            end
        end
        if (reloc)
            post(addr, BRP_ST_RELOC, 1'b0);
    endfunction

    task report(string what);
        $display("MISMATCH: %s", what);
        mismatches++;
    endtask

    // Compare one accepted result with the oldest one due
    task check_result(logic [BRP_ADDR_BITS-1:0] a, logic [BRP_STATUS_BITS-1:0] st,
                      logic last);
        reloc_result_t want;
        if (due.size() == 0) begin
            report($sformatf("unexpected result addr %h status %0d end %b", a, st, last));
            return;
        end
        want = due.pop_front();
        if (a !== want.addr)
            report($sformatf("reloc_address %h, expected %h", a, want.addr));
        if (st !== want.status)
            report($sformatf("status %0d, expected %0d", st, want.status));
        if (last !== want.table_end)
            report($sformatf("table_end %b, expected %b", last, want.table_end));
    endtask
endclass

module base_reloc_table_parser_test;

    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int SETTLE_CYCLES    = 8;
    localparam int HOLD_CYCLES      = 80;
    localparam int RANDOM_PER_PHASE = 200;
    localparam bit [BRP_CFG_BITS-1:0] TABLE_MAX = '1;

    // Ways the single parse of the run is brought to its end
    typedef enum int {
        END_AT_START,
        END_BELOW_POS,
        END_AFTER_RELOC,
        END_AFTER_PAD,
        END_BAD_SIZE,
        END_BAD_TYPE,
        END_PAST_TABLE
    } finish_kind_t;

    logic                       aclk            = 1'b0;
    logic                       aresetn         = 1'b0;
    logic                       cfg_valid       = 1'b0;
    logic [BRP_CFG_BITS-1:0]    cfg_table_bytes = '0;
    logic                       s_valid         = 1'b0;
    logic [BRP_HALF_BITS-1:0]   s_half_word     = '0;
    logic                       m_ready         = 1'b0;
    logic                       cfg_ready;
    logic                       s_ready;
    logic                       m_valid;
    logic [BRP_ADDR_BITS-1:0]   m_reloc_address;
    logic [BRP_STATUS_BITS-1:0] m_status;
    logic                       m_table_end;

    reloc_parse_checker tracker = new();

    int s_idle_pct   = 35;
    int m_idle_pct   = 82;
    int hold_left    = 0;
    int halves_sent  = 0;
    int stall_cycles = 0;

    always #4 aclk = ~aclk;

    base_reloc_table_parser dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_table_bytes (cfg_table_bytes),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_half_word     (s_half_word),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_reloc_address (m_reloc_address),
        .m_status        (m_status),
        .m_table_end     (m_table_end)
    );

    // Drive result ready: hold off on request, else stall at random
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= m_idle_pct);
        end
    end

    // Check results and watch for a hung handshake
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                tracker.check_result(m_reloc_address, m_status, m_table_end);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Offer one halfword request, after a random gap, and hold it until taken
    task automatic send_half(input bit [BRP_HALF_BITS-1:0] hw);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < s_idle_pct)
            gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_half_word <= hw;
        do @(posedge aclk); while (!s_ready);
        tracker.note_half(hw);
        halves_sent++;
    endtask

    // Drop valid and wait until every due result is in and the block is quiet
    task automatic settle();
        s_valid <= 1'b0;
        while (tracker.due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_table_len(input bit [BRP_CFG_BITS-1:0] len);
        settle();
        cfg_valid       <= 1'b1;
        cfg_table_bytes <= len;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid         <= 1'b0;
        tracker.table_len  = len;
    endtask

    task automatic send_header(input bit [31:0] page, input bit [31:0] size);
        send_half(page[15:0]);
        send_half(page[31:16]);
        send_half(size[15:0]);
        send_half(size[31:16]);
    endtask

    function automatic bit [BRP_HALF_BITS-1:0] good_entry();
        bit [BRP_TYPE_BITS-1:0]   kind;
        bit [BRP_OFFSET_BITS-1:0] offs;
        kind = ($urandom_range(0, 9) < 7) ? BRP_TYPE_RELOC : BRP_TYPE_PAD;
        offs = BRP_OFFSET_BITS'($urandom);
        return {kind, offs};
    endfunction

    // Send a block of entries at a random page; one entry may be forced
    task automatic send_block(input int entries, input int forced_at,
                              input bit [BRP_HALF_BITS-1:0] forced);
        bit [31:0] page;
        page = $urandom;
        send_header(page, 32'(BRP_HEADER_BYTES + BRP_ENTRY_BYTES * entries));
        for (int i = 0; i < entries; i++)
            send_half((i == forced_at) ? forced : good_entry());
    endtask

    initial begin
        int                       start_count;
        int                       n;
        finish_kind_t             how;
        bit [BRP_CFG_BITS-1:0]    len;
        bit [31:0]                size;
        bit [BRP_TYPE_BITS-1:0]   kind;
        bit [BRP_OFFSET_BITS-1:0] offs;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        write_table_len('0);
        write_table_len(TABLE_MAX);

        // Directed: page wrap with the largest offset, padding, an empty block
        send_header(32'hFFFF_FFFF, 12);
        send_half({BRP_TYPE_RELOC, 12'hFFF});
        send_half({BRP_TYPE_PAD, 12'hFFF});
        send_header(32'h0000_0000, BRP_HEADER_BYTES);
        send_header(32'h8000_1000, 16);
        send_half({BRP_TYPE_RELOC, 12'h000});
        send_half({BRP_TYPE_PAD, 12'h000});
        send_half({BRP_TYPE_RELOC, 12'hABC});
        send_half({BRP_TYPE_RELOC, 12'h555});

        // Random blocks under three idling patterns
        for (int p = 0; p < 3; p++) begin
            s_idle_pct = (p == 0) ? 35 : (p == 1) ? 82 : 0;
            m_idle_pct = (p == 0) ? 82 : (p == 1) ? 35 : 0;
            if (p == 1)
                write_table_len(BRP_CFG_BITS'($urandom_range(24'h01_0000, TABLE_MAX)));
            if (p == 2) begin
                write_table_len(BRP_CFG_BITS'($urandom_range(24'h00_8000, 24'h00_FFFF)));
                hold_left <= HOLD_CYCLES;
            end
            start_count = halves_sent;
            while (halves_sent - start_count < RANDOM_PER_PHASE)
                send_block($urandom_range(0, 6) * 2, -1, '0);
        end

        // Finish the parse one way, chosen at random
        how = finish_kind_t'($urandom_range(0, 6));
        n   = $urandom_range(1, 4) * 2;
        offs = BRP_OFFSET_BITS'($urandom);
        case (how)
            END_AT_START: begin
                write_table_len(BRP_CFG_BITS'(tracker.pos + $urandom_range(0, 8)));
                send_half(BRP_HALF_BITS'($urandom));
            end
            END_BELOW_POS: begin
                write_table_len($urandom_range(0, 1) ? '0 :
                                BRP_CFG_BITS'($urandom_range(0, tracker.pos - 1)));
                send_half(BRP_HALF_BITS'($urandom));
            end
            END_AFTER_RELOC, END_AFTER_PAD: begin
                write_table_len(BRP_CFG_BITS'(tracker.pos + BRP_HEADER_BYTES +
                                              BRP_ENTRY_BYTES * n +
                                              $urandom_range(0, 8)));
                kind = (how == END_AFTER_RELOC) ? BRP_TYPE_RELOC : BRP_TYPE_PAD;
                send_block(n, n - 1, {kind, offs});
            end
            END_BAD_SIZE: begin
                size = $urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom;
                if (size >= BRP_HEADER_BYTES && size[1:0] == 2'b00)
                    size[0] = 1'b1;
                send_header($urandom, size);
            end
            END_BAD_TYPE: begin
                kind = BRP_TYPE_BITS'($urandom_range(1, 14));
                if (kind >= BRP_TYPE_RELOC)
                    kind = kind + 4'd1;
                send_block(n, $urandom_range(0, n - 1), {kind, offs});
            end
            default: begin
                if ($urandom_range(0, 1)) begin
                    size      = $urandom | 32'h0100_0000;
                    size[1:0] = 2'b00;
                end else begin
                    len = BRP_CFG_BITS'(tracker.pos + 9 + $urandom_range(0, 40));
                    write_table_len(len);
                    size = (32'(len - tracker.pos) + 32'd4) & ~32'd3;
                end
                send_header($urandom, size);
            end
        endcase

        // Trailing halfwords after the end are dropped by the block
        repeat (16) send_half(BRP_HALF_BITS'($urandom));
        settle();

        if (tracker.mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
+incdir+rtl
rtl/brp_pkg.sv
rtl/brp_queue.sv
rtl/brp_front.sv
rtl/brp_back.sv
rtl/base_reloc_table_parser.sv
rtl/brp_checker.sv
sim/base_reloc_table_parser_test.sv
